[hw/rtl/wmad_pkg.sv]
// Shared types and constants of the windowed mean absolute deviation unit.
// Depends on nothing; wmad_queue, wmad_front, wmad_back and the top level refer to it by scoped names.
`default_nettype none

package wmad_pkg;

    localparam int DEF_WINDOW   = 64;
    localparam int DEF_CHANNELS = 2;
    localparam int QUEUE_DEPTH  = 4;

    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 16;
    localparam int FRESH_W    = 2;
    localparam int INTERVAL_W = 10;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd1;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_CONSUME = 1'b1;

    typedef struct packed {
        logic                mode;
        logic                channel;
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   time_ms;
    } in_t;

    typedef struct packed {
        logic               accepted;
        logic               window_done;
        logic [LEVEL_W-1:0] level;
        logic [FRESH_W-1:0] fresh_flags;
    } out_t;

    // Classified transaction handed from the front end to the back end.
    typedef struct packed {
        logic mode;
        logic channel;
        logic ch_ok;
        logic accepted;
        logic done;
    } cmd_t;

    // Back end tells the front end that a channel's window walk has finished.
    typedef struct packed {
        logic valid;
        logic channel;
    } clr_t;

endpackage

`default_nettype wire

[hw/rtl/wmad_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module wmad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wmad_queue.sv]
// Small command FIFO between the front end and the back end.
// Depends on wmad_pkg for the command type.
`default_nettype none

module wmad_queue #(
    parameter int DEPTH = wmad_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire wmad_pkg::cmd_t  push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output wmad_pkg::cmd_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wmad_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wmad_front.sv]
// Front end: takes input transactions, applies the interval check, fills the window RAM
// and queues a classified command. Depends on wmad_pkg.
`default_nettype none

module wmad_front #(
    parameter int WINDOW   = wmad_pkg::DEF_WINDOW,
    parameter int CHANNELS = wmad_pkg::DEF_CHANNELS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [wmad_pkg::INTERVAL_W-1:0]       cfg_wr_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire wmad_pkg::in_t                         s_data,
    input  wire logic                                  q_full,
    output logic                                       q_push,
    output wmad_pkg::cmd_t                             q_data,
    output logic                                       wr_en,
    output logic [$clog2(CHANNELS*WINDOW)-1:0]         wr_addr,
    output logic [wmad_pkg::SAMPLE_W-1:0]              wr_data,
    input  wire wmad_pkg::clr_t                        clr,
    output logic [CHANNELS-1:0]                        busy_o
);

    localparam int IDX_W    = $clog2(WINDOW);
    localparam int ADDR_W   = $clog2(CHANNELS * WINDOW);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [wmad_pkg::INTERVAL_W-1:0] interval_reg;
    logic [IDX_W-1:0]                fill_reg [CHANNELS];
    logic [wmad_pkg::TIME_W-1:0]     last_reg [CHANNELS];
    logic [CHANNELS-1:0]             busy_reg, busy_next;

    logic [CH_IDX_W-1:0]         ch_idx;
    logic                        ch_ok;
    logic                        is_sample;
    logic [wmad_pkg::TIME_W-1:0] elapsed;
    logic                        take;
    logic                        accept;
    logic                        completes;
    logic [IDX_W-1:0]            fill_cur;

    assign ch_idx    = CH_IDX_W'(s_data.channel);
    assign ch_ok     = ({31'b0, s_data.channel} < 32'(CHANNELS));
    assign is_sample = (s_data.mode == wmad_pkg::MODE_SAMPLE);
    assign fill_cur  = fill_reg[ch_idx];
    assign elapsed   = s_data.time_ms - last_reg[ch_idx];
    assign take      = ch_ok && is_sample
                       && (elapsed >= wmad_pkg::TIME_W'(interval_reg));
    assign completes = take && (fill_cur == IDX_W'(WINDOW - 1));

    // A sample for a channel whose window is still being walked would overwrite it.
    assign s_ready = !q_full && !(is_sample && ch_ok && busy_reg[ch_idx]);
    assign accept  = s_valid && s_ready;

    assign q_push        = accept;
    assign q_data.mode     = s_data.mode;
    assign q_data.channel  = s_data.channel;
    assign q_data.ch_ok    = ch_ok;
    assign q_data.accepted = take;
    assign q_data.done     = completes;

    assign wr_en   = accept && take;
    assign wr_addr = ADDR_W'(s_data.channel) * ADDR_W'(WINDOW) + ADDR_W'(fill_cur);
    assign wr_data = s_data.sample;

    assign busy_o = busy_reg;

    always_comb begin
        busy_next = busy_reg;
        if (clr.valid) begin
            busy_next[CH_IDX_W'(clr.channel)] = 1'b0;
        end
        if (accept && completes) begin
            busy_next[ch_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= wmad_pkg::INTERVAL_RESET;
            busy_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                fill_reg[i] <= '0;
                last_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                interval_reg <= cfg_wr_data;
            end
            busy_reg <= busy_next;
            if (accept && take) begin
                fill_reg[ch_idx] <= completes ? '0 : fill_cur + 1'b1;
                last_reg[ch_idx] <= s_data.time_ms;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wmad_back.sv]
// Back end: executes queued commands, walks a full window twice through the RAM read
// port and divides by the power-of-two window length with a shift. Depends on wmad_pkg.
`default_nettype none

module wmad_back #(
    parameter int WINDOW   = wmad_pkg::DEF_WINDOW,
    parameter int CHANNELS = wmad_pkg::DEF_CHANNELS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_empty,
    input  wire wmad_pkg::cmd_t                  q_head,
    output logic                                 q_pop,
    output logic                                 rd_en,
    output logic [$clog2(CHANNELS*WINDOW)-1:0]   rd_addr,
    input  wire logic [wmad_pkg::SAMPLE_W-1:0]   rd_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output wmad_pkg::out_t                       m_data,
    output wmad_pkg::clr_t                       clr
);

    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int ADDR_W   = $clog2(CHANNELS * WINDOW);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LVL_W    = wmad_pkg::LEVEL_W;
    localparam int SUM_W    = wmad_pkg::SAMPLE_W + $clog2(WINDOW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;

    logic [2:0]                   state_reg, state_next;
    wmad_pkg::cmd_t               cur_reg, cur_next;
    logic                         pass_reg, pass_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [SUM_W-1:0]             acc_reg, acc_next;
    logic [LVL_W-1:0]             quot_reg, quot_next;
    logic [LVL_W-1:0]             mean_reg, mean_next;
    logic [LVL_W-1:0]             level_reg [CHANNELS];
    logic [LVL_W-1:0]             level_next [CHANNELS];
    logic [wmad_pkg::FRESH_W-1:0] fresh_reg, fresh_next;
    logic                         m_valid_reg, m_valid_next;
    wmad_pkg::out_t               m_data_reg, m_data_next;

    logic                         out_free;
    logic                         issuing;
    logic [LVL_W-1:0]             abs_dev;
    logic [wmad_pkg::FRESH_W-1:0] fresh_mod;
    logic [LVL_W-1:0]             head_level;

    assign out_free = !m_valid_reg || m_ready;
    assign issuing  = (cnt_reg != CNT_W'(WINDOW));
    assign abs_dev  = (rd_data >= mean_reg) ? rd_data - mean_reg : mean_reg - rd_data;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign rd_addr  = ADDR_W'(cur_reg.channel) * ADDR_W'(WINDOW)
                      + ADDR_W'(cnt_reg[IDX_W-1:0]);

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        pass_next    = pass_reg;
        cnt_next     = cnt_reg;
        rd_vld_next  = 1'b0;
        acc_next     = acc_reg;
        quot_next    = quot_reg;
        mean_next    = mean_reg;
        level_next   = level_reg;
        fresh_next   = fresh_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        clr.valid    = 1'b0;
        clr.channel  = cur_reg.channel;
        fresh_mod    = fresh_reg;
        head_level   = q_head.ch_ok ? level_reg[CH_IDX_W'(q_head.channel)] : '0;

        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    if (q_head.done) begin
                        // Window complete: start the first pass, the sum of entries.
                        q_pop     = 1'b1;
                        cur_next  = q_head;
                        pass_next = 1'b0;
                        cnt_next  = '0;
                        acc_next  = '0;
                        state_next = S_WALK;
                    end else if (out_free) begin
                        q_pop = 1'b1;
                        if (q_head.ch_ok && (q_head.mode == wmad_pkg::MODE_CONSUME)) begin
                            fresh_mod[q_head.channel] = 1'b0;
                        end
                        fresh_next               = fresh_mod;
                        m_valid_next             = 1'b1;
                        m_data_next.accepted     = q_head.accepted;
                        m_data_next.window_done  = 1'b0;
                        m_data_next.level        = head_level;
                        m_data_next.fresh_flags  = fresh_mod;
                    end
                end
            end
            S_WALK: begin
                rd_en       = issuing;
                rd_vld_next = issuing;
                if (issuing) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    acc_next = acc_reg + SUM_W'(pass_reg ? abs_dev : rd_data);
                end
                if (!issuing && !rd_vld_reg) begin
                    if (!pass_reg) begin
                        // Mean is known: second pass sums the absolute deviations.
                        mean_next = LVL_W'(acc_reg >> IDX_W);
                        pass_next = 1'b1;
                        cnt_next  = '0;
                        acc_next  = '0;
                    end else begin
                        quot_next  = LVL_W'(acc_reg >> IDX_W);
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    fresh_mod[cur_reg.channel]             = 1'b1;
                    fresh_next                             = fresh_mod;
                    level_next[CH_IDX_W'(cur_reg.channel)] = quot_reg;
                    m_valid_next             = 1'b1;
                    m_data_next.accepted     = 1'b1;
                    m_data_next.window_done  = 1'b1;
                    m_data_next.level        = quot_reg;
                    m_data_next.fresh_flags  = fresh_mod;
                    clr.valid                = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_vld_reg  <= 1'b0;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                level_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
            level_reg   <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        pass_reg   <= pass_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        quot_reg   <= quot_next;
        mean_reg   <= mean_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

[hw/rtl/windowed_mean_abs_deviation_unit.sv]
// Top level of the windowed mean absolute deviation unit.
// Depends on wmad_pkg, wmad_ram, wmad_queue, wmad_front and wmad_back.
//
// Usage: each input transaction on s_valid/s_ready carries s_data (mode, channel, sample,
// time_ms) and produces exactly one result transaction on m_valid/m_ready carrying m_data
// (accepted, window_done, level, fresh_flags), in input order. A mode 0 transaction offers
// a sample, which is stored when at least cfg_wr_data milliseconds have elapsed
// since that channel's last stored sample. The sample that fills a window triggers two
// passes over the window RAM: one for the mean, one for the mean absolute deviation.
// A mode 1 transaction returns the channel's level and clears its fresh flag.
// WINDOW must be a power of two, since both means are taken with a shift.
//
// Timing: the front end takes one transaction per cycle while the command queue has room
// and no sample is offered for a channel whose window is still being walked. A transaction
// that completes no window has its result registered in the command queue, then in the
// output register, when the back end is idle. One that completes a window holds the back
// end for a pop, two walks of the window through the single registered RAM read port, and
// an output step. A new sample for that channel waits until the walk is over; others queue.
//
// Reset (aresetn low, synchronous) clears fill counts, last times, levels, fresh flags and
// the interval to 1. When the receiver stalls, the output register holds its result and
// the queue fills, after which s_ready drops.
`default_nettype none

module windowed_mean_abs_deviation_unit #(
    parameter int WINDOW   = wmad_pkg::DEF_WINDOW,
    parameter int CHANNELS = wmad_pkg::DEF_CHANNELS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [wmad_pkg::INTERVAL_W-1:0] cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire wmad_pkg::in_t                   s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output wmad_pkg::out_t                       m_data
);

    localparam int ADDR_W = $clog2(CHANNELS * WINDOW);

    // Command path between the two halves.
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    wmad_pkg::cmd_t q_in;
    wmad_pkg::cmd_t q_head;

    // Window RAM ports: the front end writes, the back end reads.
    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             ram_wr_addr;
    logic [wmad_pkg::SAMPLE_W-1:0] ram_wr_data;
    logic                          ram_rd_en;
    logic [ADDR_W-1:0]             ram_rd_addr;
    logic [wmad_pkg::SAMPLE_W-1:0] ram_rd_data;

    // The back end releases a channel once its window walk is finished.
    wmad_pkg::clr_t      clr;
    logic [CHANNELS-1:0] busy;

    wmad_front #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in),
        .wr_en       (ram_wr_en),
        .wr_addr     (ram_wr_addr),
        .wr_data     (ram_wr_data),
        .clr         (clr),
        .busy_o      (busy)
    );

    wmad_queue #(
        .DEPTH (wmad_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    wmad_ram #(
        .WIDTH (wmad_pkg::SAMPLE_W),
        .DEPTH (CHANNELS * WINDOW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    wmad_back #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .clr     (clr)
    );

    // A completed window always reports a stored sample and a set fresh flag.
    a_done_implies_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.window_done) |-> (m_data.accepted && (m_data.fresh_flags != '0)))
        else $error("window_done result without accepted sample or fresh flag");

    // The front end must hold off while the command queue is full.
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_ready)
        else $error("input ready while command queue is full");

    // A channel is only released after it was marked busy.
    a_clear_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        clr.valid |-> (busy != '0))
        else $error("window walk finished for no busy channel");

    // Reset empties the output register.
    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for windowed_mean_abs_deviation_unit: random and directed sample
// and consume transactions checked against an in-bench activity meter model.
// Depends on wmad_pkg and the unit's RTL only.

module tb_top;

    localparam int          WIN_LEN      = wmad_pkg::DEF_WINDOW;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [wmad_pkg::INTERVAL_W-1:0] cfg_wr_data = '0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    wmad_pkg::in_t                   s_data      = '0;
    logic                            m_valid;
    logic                            m_ready     = 1'b0;
    wmad_pkg::out_t                  m_data;

    windowed_mean_abs_deviation_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // Meter model state, mirrored from the block's behavior.
    logic [wmad_pkg::SAMPLE_W-1:0]   win_mem [2][WIN_LEN];
    int unsigned                     fill_pos [2];
    logic [wmad_pkg::TIME_W-1:0]     last_ms [2];
    logic [wmad_pkg::LEVEL_W-1:0]    level_reg [2];
    logic [wmad_pkg::FRESH_W-1:0]    fresh_reg;
    logic [wmad_pkg::INTERVAL_W-1:0] interval_ms;

    // Stimulus side: last accepted time as seen when items are planned.
    logic [wmad_pkg::TIME_W-1:0]     planned_last [2];
    logic [wmad_pkg::SAMPLE_W-1:0]   sample_base;

    wmad_pkg::in_t  offer_queue [$];
    wmad_pkg::out_t predicted_meter_out [$];
    int             sender_idle_pct   = 0;
    int             receiver_idle_pct = 0;
    bit             offer_taken       = 1'b0;
    bit             hold_armed        = 1'b0;
    bit             hold_taken        = 1'b0;
    int             hold_left         = 0;
    int unsigned    cycle_count       = 0;
    int             error_count       = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Computes the result of one accepted transaction and advances the meter state.
    function automatic wmad_pkg::out_t predict_meter(wmad_pkg::in_t item);
        wmad_pkg::out_t r;
        logic           ch;
        logic [31:0]    elapsed;
        int unsigned    sum;
        int unsigned    mean;
        int unsigned    dev;
        int unsigned    v;
        r  = '0;
        ch = item.channel;
        if (item.mode == wmad_pkg::MODE_SAMPLE) begin
            elapsed = item.time_ms - last_ms[ch];
            if (elapsed >= 32'(interval_ms)) begin
                win_mem[ch][fill_pos[ch]] = item.sample;
                last_ms[ch] = item.time_ms;
                r.accepted = 1'b1;
                if (fill_pos[ch] == WIN_LEN - 1) begin
                    // Window full: mean, then mean absolute deviation, both truncated.
                    fill_pos[ch] = 0;
                    sum = 0;
                    for (int k = 0; k < WIN_LEN; k++) sum += win_mem[ch][k];
                    mean = sum / WIN_LEN;
                    dev = 0;
                    for (int k = 0; k < WIN_LEN; k++) begin
                        v = win_mem[ch][k];
                        dev += (v >= mean) ? (v - mean) : (mean - v);
                    end
                    level_reg[ch] = wmad_pkg::LEVEL_W'(dev / WIN_LEN);
                    fresh_reg[ch] = 1'b1;
                    r.window_done = 1'b1;
                end else begin
                    fill_pos[ch] = fill_pos[ch] + 1;
                end
            end
        end else begin
            fresh_reg[ch] = 1'b0;
        end
        r.level       = level_reg[ch];
        r.fresh_flags = fresh_reg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("tb: mismatch on %s at cycle %0d: got %0h, expected %0h",
                 what, cycle_count, got, want);
    endtask

    // Queues one transaction, tracking which samples the block will store.
    function automatic void queue_item(wmad_pkg::in_t item);
        logic [31:0] elapsed;
        elapsed = item.time_ms - planned_last[item.channel];
        if (item.mode == wmad_pkg::MODE_SAMPLE && elapsed >= 32'(interval_ms))
            planned_last[item.channel] = item.time_ms;
        offer_queue.push_back(item);
    endfunction

    function automatic void queue_fields(logic mode, logic ch,
                                         logic [wmad_pkg::SAMPLE_W-1:0] smp,
                                         logic [wmad_pkg::TIME_W-1:0] t);
        wmad_pkg::in_t item;
        item.mode    = mode;
        item.channel = ch;
        item.sample  = smp;
        item.time_ms = t;
        queue_item(item);
    endfunction

    // Mostly well-timed samples so that windows fill, with early, random-time and
    // consume transactions mixed in.
    function automatic void plan_items(int count);
        wmad_pkg::in_t item;
        int            pick;
        sample_base = wmad_pkg::SAMPLE_W'($urandom_range(65535 - 255));
        for (int n = 0; n < count; n++) begin
            item.channel = 1'($urandom_range(1));
            item.time_ms = $urandom();
            pick = $urandom_range(99);
            if (pick < 40)
                item.sample = wmad_pkg::SAMPLE_W'($urandom());
            else if (pick < 80)
                item.sample = sample_base + wmad_pkg::SAMPLE_W'($urandom_range(255));
            else
                item.sample = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
            pick = $urandom_range(99);
            if (pick < 12) begin
                item.mode = wmad_pkg::MODE_CONSUME;
            end else begin
                item.mode = wmad_pkg::MODE_SAMPLE;
                if (pick < 82)
                    item.time_ms = planned_last[item.channel] + 32'(interval_ms)
                                   + $urandom_range(3);
                else if (pick < 92 && interval_ms != 0)
                    item.time_ms = planned_last[item.channel]
                                   + $urandom_range(32'(interval_ms) - 1);
            end
            queue_item(item);
        end
    endfunction

    task automatic set_interval(input logic [wmad_pkg::INTERVAL_W-1:0] value);
        @(negedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        interval_ms = value;
        @(posedge aclk);
    endtask

    // Waits until every transaction has gone through and its result has come back,
    // then lets a window walk finish before anything else happens.
    task automatic wait_idle();
        do @(posedge aclk);
        while (offer_queue.size() != 0 || s_valid || predicted_meter_out.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Input driver: presents the next queued transaction after the previous one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || offer_taken) begin
            offer_taken = 1'b0;
            if (offer_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_data  <= offer_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off when armed.
    always @(negedge aclk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Monitor: predicts on every accepted input, checks every accepted result.
    always @(posedge aclk) begin
        wmad_pkg::out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted_meter_out.push_back(predict_meter(s_data));
                offer_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (predicted_meter_out.size() == 0) begin
                    report_mismatch("result with nothing pending", m_data, 0);
                end else begin
                    want = predicted_meter_out.pop_front();
                    if (m_data.accepted !== want.accepted)
                        report_mismatch("accepted", m_data.accepted, want.accepted);
                    if (m_data.window_done !== want.window_done)
                        report_mismatch("window_done", m_data.window_done, want.window_done);
                    if (m_data.level !== want.level)
                        report_mismatch("level", m_data.level, want.level);
                    if (m_data.fresh_flags !== want.fresh_flags)
                        report_mismatch("fresh_flags", m_data.fresh_flags, want.fresh_flags);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        interval_ms = wmad_pkg::INTERVAL_RESET;
        fresh_reg   = '0;
        for (int c = 0; c < 2; c++) begin
            fill_pos[c]     = 0;
            last_ms[c]      = '0;
            level_reg[c]    = '0;
            planned_last[c] = '0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct   = 23;
        receiver_idle_pct = 83;

        // Directed part at the reset interval of one millisecond.
        queue_fields(wmad_pkg::MODE_CONSUME, 1'b0, 16'h0000, 32'h0000_0000); // nothing fresh
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b0, 16'h0000, 32'h0000_0000); // too early
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b1, 16'h8000, 32'h0000_0000); // wraps, gap 1
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b1, 16'h7FFF, 32'h0000_0000); // same time
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b0, 16'hFFFF, 32'h0000_0001);
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b0, 16'h0001, 32'h0000_0000); // time goes back
        queue_fields(wmad_pkg::MODE_CONSUME, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        queue_fields(wmad_pkg::MODE_CONSUME, 1'b0, 16'h1234, 32'h8000_0000);
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b0, 16'hAAAA, 32'h5555_5555);
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b1, 16'h5555, 32'hAAAA_AAAA);
        queue_fields(wmad_pkg::MODE_SAMPLE,  1'b0, 16'h5555, 32'h5555_5556); // gap = interval
        wait_idle();

        // Zero interval: every sample is stored, so windows complete quickly.
        set_interval('0);
        plan_items(150);
        wait_idle();

        sender_idle_pct   = 83;
        receiver_idle_pct = 23;
        set_interval('1);
        plan_items(100);
        wait_idle();

        set_interval(wmad_pkg::INTERVAL_W'($urandom_range(2, 999)));
        plan_items(100);
        wait_idle();

        // No idling; the receiver holds off long enough to back up the input.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_interval(wmad_pkg::INTERVAL_W'(1000));
        plan_items(100);
        hold_armed = 1'b1;
        wait_idle();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
